/* src/wcc_pkg.sv */
// Shared types, constants and helpers for the windowed coincidence counter.
// No dependencies; every other file in src imports this package.
package wcc_pkg;

    localparam int TIME_BITS      = 48;
    localparam int COUNT_BITS     = 32;
    localparam int NUM_CONDITIONS = 8;
    localparam int NUM_CURVES     = 6;
    localparam int NUM_AND_CURVES = 3;
    localparam int CHAN_BITS      = 8;
    localparam int BOUND_BITS     = 32;
    localparam int IDX_BITS       = $clog2(NUM_CONDITIONS);
    localparam int OUT_BITS       = 32;
    localparam int SUM_BITS       = ((TIME_BITS > BOUND_BITS) ? TIME_BITS : BOUND_BITS) + 2;

    // Slave-side tdata layout, lowest field first
    localparam int CHAN_LSB      = 0;
    localparam int TIME_LSB      = CHAN_LSB + CHAN_BITS;
    localparam int IDX_LSB       = TIME_LSB + TIME_BITS;
    localparam int LOW_LSB       = IDX_LSB + IDX_BITS;
    localparam int HIGH_LSB      = LOW_LSB + BOUND_BITS;
    localparam int IN_DATA_BITS  = HIGH_LSB + BOUND_BITS;
    localparam int IN_TDATA_BITS = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = NUM_CURVES * OUT_BITS;

    typedef logic [1:0]                  t_cmd;
    typedef logic [CHAN_BITS-1:0]        t_chan;
    typedef logic [TIME_BITS-1:0]        t_time;
    typedef logic [IDX_BITS-1:0]         t_idx;
    typedef logic signed [BOUND_BITS-1:0] t_bound;
    typedef logic signed [SUM_BITS-1:0]  t_sum;
    typedef logic [COUNT_BITS-1:0]       t_count;
    typedef logic [NUM_CONDITIONS-1:0]   t_flags;
    typedef logic [2:0]                  t_reg_idx;
    typedef logic [1:0]                  t_src;

    localparam t_cmd CMD_EVENT = 2'd0;
    localparam t_cmd CMD_ENTRY = 2'd1;
    localparam t_cmd CMD_DUMP  = 2'd2;

    localparam t_reg_idx REG_START_CHAN = 3'd0;
    localparam t_reg_idx REG_SRC_A_CHAN = 3'd1;
    localparam t_reg_idx REG_SRC_B_CHAN = 3'd2;
    localparam t_reg_idx REG_SRC_C_CHAN = 3'd3;
    localparam t_reg_idx REG_DELAY_OFS  = 3'd4;
    localparam t_reg_idx REG_COND_SRCS  = 3'd5;
    localparam t_reg_idx REG_PAIR_CURVE = 3'd6;

    localparam t_src SRC_A     = 2'd0;
    localparam t_src SRC_B     = 2'd1;
    localparam t_src SRC_C     = 2'd2;
    localparam t_src SRC_NEVER = 2'd3;

    // Channel selection seen by the condition compare
    typedef struct packed {
        t_chan                     chan_a;
        t_chan                     chan_b;
        t_chan                     chan_c;
        logic [2*NUM_CONDITIONS-1:0] sources;
    } t_src_cfg;

    // Control from the window logic to the counter bank
    typedef struct packed {
        logic   close_open;  // an open window closes with this word
        logic   dump;        // report and clear
        t_flags flags;       // condition flags of the closing window
    } t_cnt_ctrl;

    function automatic logic [OUT_BITS-1:0] out_word(input t_count c);
        logic [63:0] w;
        w = 64'(c);
        return w[OUT_BITS-1:0];
    endfunction

endpackage

/* src/wcc_cond_match.sv */
// Parallel window-condition compare for one stop word.
// Depends on wcc_pkg.
module wcc_cond_match import wcc_pkg::*; (
    input  t_src_cfg i_src_cfg,
    input  t_chan    i_channel,
    input  t_sum     i_delay,                  // stop - start + offset
    input  t_bound   i_lows  [NUM_CONDITIONS],
    input  t_bound   i_highs [NUM_CONDITIONS],
    output t_flags   o_hit
);

    always_comb begin
        t_src  src;
        t_chan want;
        logic  chan_ok;
        o_hit = '0;
        for (int k = 0; k < NUM_CONDITIONS; k++) begin
            src     = i_src_cfg.sources[2*k +: 2];
            want    = i_src_cfg.chan_a;
            chan_ok = 1'b1;
            case (src)
                SRC_A: want = i_src_cfg.chan_a;
                SRC_B: want = i_src_cfg.chan_b;
                SRC_C: want = i_src_cfg.chan_c;
                default: chan_ok = 1'b0;
            endcase
            o_hit[k] = chan_ok && (i_channel == want) &&
                       (i_delay > t_sum'(i_lows[k])) && (i_delay < t_sum'(i_highs[k]));
        end
    end

endmodule

/* src/wcc_counters.sv */
// Six saturating coincidence counters, bumped when a window closes and cleared by a dump.
// Depends on wcc_pkg.
module wcc_counters import wcc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_cnt_ctrl i_ctrl,
    input  logic [3:0] i_pair_curves,
    output t_count    o_counts [NUM_CURVES]
);

    t_count r_count [NUM_CURVES];
    logic [NUM_AND_CURVES-1:0] met;
    logic [NUM_CURVES-1:0]     bump;
    logic                      either;

    function automatic logic pair_met(input logic [1:0] sel,
                                      input logic [NUM_AND_CURVES-1:0] m);
        logic r;
        r = 1'b0;
        case (sel)
            2'd0: r = m[0];
            2'd1: r = m[1];
            2'd2: r = m[2];
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    always_comb begin
        for (int c = 0; c < NUM_AND_CURVES; c++) begin
            met[c] = i_ctrl.flags[2*c] && i_ctrl.flags[2*c+1];
        end
        either  = pair_met(i_pair_curves[1:0], met) || pair_met(i_pair_curves[3:2], met);
        bump[0] = met[0];
        bump[1] = met[1];
        bump[2] = met[2];
        bump[3] = either;
        bump[4] = either && i_ctrl.flags[6];
        bump[5] = either && i_ctrl.flags[7];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CURVES; c++) r_count[c] <= '0;
        end else if (i_advance) begin
            for (int c = 0; c < NUM_CURVES; c++) begin
                if (i_ctrl.dump) begin
                    r_count[c] <= '0;
                end else if (i_ctrl.close_open && bump[c] && (r_count[c] != '1)) begin
                    r_count[c] <= r_count[c] + 1'b1;
                end
            end
        end
    end

    assign o_counts = r_count;

endmodule

/* src/windowed_coincidence_counter.sv */
// Top level of the windowed coincidence counter: input register, window state,
// configuration registers and result register. Depends on wcc_pkg,
// wcc_cond_match and wcc_counters.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+------------------------------------------
//  s_axis   | in  | tvalid/tready        | tdata: event and window-entry fields,
//           |     |                      | tuser: cmd, tlast: last_in_batch
//  m_axis   | out | tvalid/tready        | tdata: six 32-bit counts (dump result)
//  cfg      | in  | valid/ready (ready=1)| index 3 bits, data 32 bits
//
// One word per cycle unless a dump word is held: a word is first registered in the
// input register, then the window compare, flag and counter update run in the same cycle.
// A dump word waits in the input register only while the result register is full
// and the master side holds tready low; words behind it wait with it, and nothing
// else stalls the input.
// Synchronous active-low reset clears window state, entries, counters and
// configuration to their defaults.
module windowed_coincidence_counter import wcc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // channel, timetag, entry_index, bound_low, bound_high, zero pad (lowest first)
    input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
    // cmd
    input  logic [1:0]                s_axis_tuser,
    input  logic                      s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // count_curve0, count_curve1, count_curve2, count_either_pair,
    // count_pair_and_four, count_pair_and_five (lowest first)
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  t_reg_idx                  i_cfg_index,
    input  logic [31:0]               i_cfg_data
);

    // configuration
    t_chan                       r_start_chan;
    t_src_cfg                    r_src_cfg;
    t_bound                      r_delay_ofs;
    logic [3:0]                  r_pair_curves;

    // input register
    logic   r_in_valid;
    t_cmd   r_in_cmd;
    t_chan  r_in_chan;
    t_time  r_in_time;
    logic   r_in_last;
    t_idx   r_in_idx;
    t_bound r_in_low;
    t_bound r_in_high;

    // window state
    logic   r_open;
    t_time  r_start_time;
    t_flags r_flags;
    t_bound r_lows  [NUM_CONDITIONS];
    t_bound r_highs [NUM_CONDITIONS];

    // result register
    logic                      r_out_valid;
    logic [OUT_TDATA_BITS-1:0] r_out_data;

    logic      advance;
    logic      is_event, is_start, is_stop, closing;
    t_sum      delay;
    t_flags    hit;
    t_flags    flags_upd;
    t_cnt_ctrl cnt_ctrl;
    t_count    counts [NUM_CURVES];
    logic      n_open;
    t_flags    n_flags;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_chan      <= 8'd0;
            r_src_cfg.chan_a  <= 8'd1;
            r_src_cfg.chan_b  <= 8'd2;
            r_src_cfg.chan_c  <= 8'd3;
            r_src_cfg.sources <= '1;
            r_delay_ofs       <= '0;
            r_pair_curves     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_START_CHAN: r_start_chan      <= i_cfg_data[CHAN_BITS-1:0];
                REG_SRC_A_CHAN: r_src_cfg.chan_a  <= i_cfg_data[CHAN_BITS-1:0];
                REG_SRC_B_CHAN: r_src_cfg.chan_b  <= i_cfg_data[CHAN_BITS-1:0];
                REG_SRC_C_CHAN: r_src_cfg.chan_c  <= i_cfg_data[CHAN_BITS-1:0];
                REG_DELAY_OFS:  r_delay_ofs       <= i_cfg_data;
                REG_COND_SRCS:  r_src_cfg.sources <= i_cfg_data[2*NUM_CONDITIONS-1:0];
                REG_PAIR_CURVE: r_pair_curves     <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // A dump word holds in the input register while the result is still unread
    assign advance       = r_in_valid &&
                           ((r_in_cmd != CMD_DUMP) || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd  <= s_axis_tuser;
            r_in_last <= s_axis_tlast;
            r_in_chan <= s_axis_tdata[CHAN_LSB +: CHAN_BITS];
            r_in_time <= s_axis_tdata[TIME_LSB +: TIME_BITS];
            r_in_idx  <= s_axis_tdata[IDX_LSB +: IDX_BITS];
            r_in_low  <= s_axis_tdata[LOW_LSB +: BOUND_BITS];
            r_in_high <= s_axis_tdata[HIGH_LSB +: BOUND_BITS];
        end
    end

    assign delay = t_sum'({1'b0, r_in_time}) - t_sum'({1'b0, r_start_time})
                 + t_sum'(r_delay_ofs);

    wcc_cond_match u_match (
        .i_src_cfg (r_src_cfg),
        .i_channel (r_in_chan),
        .i_delay   (delay),
        .i_lows    (r_lows),
        .i_highs   (r_highs),
        .o_hit     (hit)
    );

    always_comb begin
        is_event  = (r_in_cmd == CMD_EVENT);
        is_start  = is_event && (r_in_chan == r_start_chan);
        is_stop   = is_event && !is_start && r_open;
        flags_upd = is_stop ? (r_flags | hit) : r_flags;
        // a start closes the old window; a last event word closes whatever is open
        closing   = is_event && (is_start || r_in_last);
        n_open    = is_start ? !r_in_last : (closing ? 1'b0 : r_open);
        n_flags   = closing ? '0 : flags_upd;

        cnt_ctrl.close_open = closing && r_open;
        cnt_ctrl.dump       = (r_in_cmd == CMD_DUMP);
        cnt_ctrl.flags      = flags_upd;
    end

    wcc_counters u_counters (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_ctrl        (cnt_ctrl),
        .i_pair_curves (r_pair_curves),
        .o_counts      (counts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open       <= 1'b0;
            r_start_time <= '0;
            r_flags      <= '0;
            for (int k = 0; k < NUM_CONDITIONS; k++) begin
                r_lows[k]  <= '0;
                r_highs[k] <= '0;
            end
        end else if (advance) begin
            r_open  <= n_open;
            r_flags <= n_flags;
            if (is_start) begin
                r_start_time <= r_in_time;
            end
            if (r_in_cmd == CMD_ENTRY) begin
                r_lows[r_in_idx]  <= r_in_low;
                r_highs[r_in_idx] <= r_in_high;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && cnt_ctrl.dump) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && cnt_ctrl.dump) begin
            for (int c = 0; c < NUM_CURVES; c++) begin
                r_out_data[c*OUT_BITS +: OUT_BITS] <= out_word(counts[c]);
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
